>>> hdl/ggd_pkg.sv
// Shared types, constants and helper functions for the go-to-goal drive controller.
// No dependencies; every other file of the block refers to this package by scoped names.
package ggd_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int DUTY_BITS = 8;
  localparam int CNT_W = $clog2(CORDIC_STEPS);
  localparam int ATAN_IDX_W = 5;
  localparam int XW = 28;
  localparam int ZW = 24;
  localparam int NUM_W = 52;
  localparam int DIV_CNT_W = $clog2(NUM_W);
  localparam int ACC_W = 56;

  localparam logic [1:0] ACT_UPDATE = 2'd0;
  localparam logic [1:0] ACT_GOAL = 2'd1;
  localparam logic [1:0] ACT_STOP = 2'd2;
  localparam logic [1:0] ACT_NONE = 2'd3;

  localparam logic [1:0] CMD_HOLD = 2'd0;
  localparam logic [1:0] CMD_DRIVE = 2'd1;
  localparam logic [1:0] CMD_OFF = 2'd2;

  localparam logic [2:0] REG_KP_LIN = 3'd0;
  localparam logic [2:0] REG_KI_LIN = 3'd1;
  localparam logic [2:0] REG_KD_LIN = 3'd2;
  localparam logic [2:0] REG_KP_ANG = 3'd3;
  localparam logic [2:0] REG_KI_ANG = 3'd4;
  localparam logic [2:0] REG_KD_ANG = 3'd5;
  localparam logic [2:0] REG_FLOOR = 3'd6;
  localparam logic [2:0] REG_CEIL = 3'd7;

  localparam logic signed [16:0] INV_GAIN = 17'sd39797;
  localparam logic [17:0] STOP_RADIUS = 18'd82;
  localparam logic signed [NUM_W-1:0] LIN_INT_LIMIT = NUM_W'(64'sd5 <<< 26);
  localparam logic signed [NUM_W-1:0] ANG_INT_LIMIT = NUM_W'(64'sd50 <<< 22);
  localparam logic signed [17:0] HALF_TURN = 18'sd11520;
  localparam logic signed [17:0] FULL_TURN = 18'sd23040;
  localparam logic signed [ZW-1:0] QUARTER_TURN = ZW'(90 * 16384);

  typedef enum logic [4:0] {
    ST_IDLE, ST_CORDIC, ST_MAG, ST_CHK, ST_WRAP,
    ST_M1, ST_M2, ST_M3, ST_M4, ST_M5, ST_M6, ST_M7, ST_M8,
    ST_DIV1, ST_DIV1B, ST_DIV2, ST_BASE, ST_TURN, ST_DRV, ST_EMIT
  } ggd_state_t;

  typedef struct packed {
    logic [DUTY_BITS-1:0] duty;
    logic fwd;
  } ggd_drive_t;

  function automatic logic signed [ZW-1:0] atan_lut(input logic [ATAN_IDX_W-1:0] idx);
    logic signed [ZW-1:0] v;
    case (idx)
      5'd0: v = 24'sd737280;
      5'd1: v = 24'sd435242;
      5'd2: v = 24'sd229970;
      5'd3: v = 24'sd116736;
      5'd4: v = 24'sd58595;
      5'd5: v = 24'sd29322;
      5'd6: v = 24'sd14667;
      5'd7: v = 24'sd7334;
      5'd8: v = 24'sd3667;
      5'd9: v = 24'sd1833;
      5'd10: v = 24'sd917;
      5'd11: v = 24'sd458;
      5'd12: v = 24'sd229;
      5'd13: v = 24'sd115;
      5'd14: v = 24'sd57;
      5'd15: v = 24'sd29;
      5'd16: v = 24'sd14;
      5'd17: v = 24'sd7;
      5'd18: v = 24'sd4;
      5'd19: v = 24'sd2;
      5'd20: v = 24'sd1;
      default: v = 24'sd0;
    endcase
    return v;
  endfunction

  function automatic ggd_drive_t drive_duty(input logic signed [26:0] base,
                                            input logic signed [26:0] turn_term,
                                            input logic [7:0] floor_v,
                                            input logic [7:0] ceil_v);
    logic signed [27:0] s;
    logic [27:0] a;
    logic [9:0] m;
    ggd_drive_t r;
    s = {base[26], base} - {turn_term[26], turn_term};
    a = s[27] ? 28'(-s) : 28'(s);
    m = a[27:18];
    r.fwd = !s[27] || (m == 10'd0);
    if (m != 10'd0 && m < {2'b0, floor_v}) m = {2'b0, floor_v};
    if (m > {2'b0, ceil_v}) m = {2'b0, ceil_v};
    r.duty = m[DUTY_BITS-1:0];
    return r;
  endfunction

endpackage

>>> hdl/ggd_cordic.sv
// Iterative CORDIC vectoring unit: one shift-add rotation per cycle.
// Depends on ggd_pkg for widths, step count and the arctangent table.
module ggd_cordic (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic signed [16:0] dx,
  input  logic signed [16:0] dy,
  output logic done,
  output logic signed [ggd_pkg::XW-1:0] mag_x,
  output logic signed [ggd_pkg::ZW-1:0] ang_z
);

  logic signed [ggd_pkg::XW-1:0] x, y, xs, ys, xi, yi;
  logic signed [ggd_pkg::ZW-1:0] z, at;
  logic [ggd_pkg::CNT_W-1:0] cnt;
  logic busy;

  assign xi = {{(ggd_pkg::XW - 25){dx[16]}}, dx, 8'b0};
  assign yi = {{(ggd_pkg::XW - 25){dy[16]}}, dy, 8'b0};
  assign xs = x >>> cnt;
  assign ys = y >>> cnt;
  assign at = ggd_pkg::atan_lut(ggd_pkg::ATAN_IDX_W'(cnt));
  assign mag_x = x;
  assign ang_z = z;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= '0;
        if (xi < 0) begin
          if (yi >= 0) begin
            x <= yi;
            y <= -xi;
            z <= ggd_pkg::QUARTER_TURN;
          end else begin
            x <= -yi;
            y <= xi;
            z <= -ggd_pkg::QUARTER_TURN;
          end
        end else begin
          x <= xi;
          y <= yi;
          z <= '0;
        end
      end else if (busy) begin
        if (y >= 0) begin
          x <= x + ys;
          y <= y - xs;
          z <= z + at;
        end else begin
          x <= x - ys;
          y <= y + xs;
          z <= z - at;
        end
        if (cnt == ggd_pkg::CNT_W'(ggd_pkg::CORDIC_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

endmodule

>>> hdl/ggd_divider.sv
// Restoring signed divider that truncates toward zero, one quotient bit per cycle.
// Depends on ggd_pkg for the numerator width.
module ggd_divider (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic signed [ggd_pkg::NUM_W-1:0] num,
  input  logic [15:0] den,
  output logic done,
  output logic signed [ggd_pkg::NUM_W-1:0] quo
);

  logic [ggd_pkg::NUM_W-1:0] sh;
  logic [15:0] rem, d;
  logic [16:0] rem_sh;
  logic [ggd_pkg::DIV_CNT_W-1:0] cnt;
  logic busy, neg, fits;

  assign rem_sh = {rem, sh[ggd_pkg::NUM_W-1]};
  assign fits = rem_sh >= {1'b0, d};
  assign quo = neg ? -$signed(sh) : $signed(sh);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= '0;
        rem <= '0;
        d <= den;
        neg <= num[ggd_pkg::NUM_W-1];
        sh <= num[ggd_pkg::NUM_W-1] ? ggd_pkg::NUM_W'(-num) : ggd_pkg::NUM_W'(num);
      end else if (busy) begin
        rem <= fits ? 16'(rem_sh - {1'b0, d}) : rem_sh[15:0];
        sh <= {sh[ggd_pkg::NUM_W-2:0], fits};
        if (cnt == ggd_pkg::DIV_CNT_W'(ggd_pkg::NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

endmodule

>>> hdl/go_to_goal_dual_pid_drive.sv
// Go-to-goal controller: sequencer, shared multiplier and PID datapath.
// Depends on ggd_pkg, ggd_cordic and ggd_divider.
// Set goal, stop and ignored beats: result one cycle after acceptance. A pose update
// that reaches the goal runs CORDIC, MAG, CHK, EMIT; a drive update adds WRAP, repeated
// per extra heading wrap, M1-M8, both divisions, BASE, TURN, DRV. The next beat waits
// for idle and a free output. Synchronous reset restores the gains and halts the drive.
module go_to_goal_dual_pid_drive (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic [1:0] action,
  input  logic signed [15:0] pos_x,
  input  logic signed [15:0] pos_y,
  input  logic signed [15:0] heading,
  input  logic [15:0] time_step,
  output logic out_valid,
  input  logic out_stall,
  output logic [1:0] command,
  output logic [ggd_pkg::DUTY_BITS-1:0] left_duty,
  output logic left_forward,
  output logic [ggd_pkg::DUTY_BITS-1:0] right_duty,
  output logic right_forward,
  output logic goal_reached,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [15:0] cfg_data
);

  ggd_pkg::ggd_state_t state, state_next;

  logic signed [15:0] kp_l, ki_l, kd_l, kp_a, ki_a, kd_a;
  logic [7:0] duty_floor, duty_ceiling;
  logic halted;
  logic signed [15:0] target_x, target_y, hd_r;
  logic [15:0] dt_r;
  logic signed [31:0] dint, aint;
  logic signed [23:0] prev_d, prev_a;
  logic [17:0] dist_q;
  logic signed [17:0] eang;
  logic signed [49:0] p, prod;
  logic signed [ggd_pkg::ACC_W-1:0] acc_l, acc_a;
  logic signed [26:0] base, turn_term;
  logic [1:0] res_cmd;
  logic res_goal;
  ggd_pkg::ggd_drive_t res_l, res_r, drv_l, drv_r;

  logic accept, out_free, run, emit;
  logic signed [16:0] mul_a;
  logic signed [32:0] mul_b;
  logic cordic_start, cordic_done, div_start, div_done;
  logic signed [ggd_pkg::XW-1:0] cx;
  logic signed [ggd_pkg::ZW-1:0] cz, zb;
  logic signed [ggd_pkg::NUM_W-1:0] div_num, div_quo;
  logic signed [49:0] pr;
  logic [17:0] dist_c;
  logic signed [17:0] eang_c;
  logic signed [24:0] diff_d, diff_a;

  function automatic logic signed [31:0] clamp_int(input logic signed [31:0] acc,
                                                   input logic signed [49:0] add,
                                                   input logic signed [ggd_pkg::NUM_W-1:0] lim);
    logic signed [ggd_pkg::NUM_W-1:0] s;
    s = ggd_pkg::NUM_W'(acc) + ggd_pkg::NUM_W'(add);
    if (s > lim) s = lim;
    else if (s < -lim) s = -lim;
    return s[31:0];
  endfunction

  function automatic logic signed [26:0] clamp_cap(input logic signed [63:0] v,
                                                   input logic [7:0] ceil_v);
    logic signed [63:0] cap, r;
    cap = $signed({38'b0, ceil_v, 18'b0});
    r = v;
    if (r > cap) r = cap;
    else if (r < -cap) r = -cap;
    return r[26:0];
  endfunction

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != ggd_pkg::ST_IDLE) || !out_free;
  assign accept = in_valid && !in_stall;
  assign run = (action == ggd_pkg::ACT_UPDATE) && !halted && (time_step != 16'd0);
  assign cfg_ready = 1'b1;
  assign emit = ((state == ggd_pkg::ST_IDLE) && accept && !run) ||
                ((state == ggd_pkg::ST_EMIT) && out_free);

  assign prod = mul_a * mul_b;
  assign pr = p + 50'sd8388608;
  assign dist_c = pr[41:24];
  assign zb = cz + ggd_pkg::ZW'(128);
  assign eang_c = 18'($signed(zb[23:8])) - 18'(hd_r);
  assign diff_d = $signed({7'b0, dist_q}) - 25'(prev_d);
  assign diff_a = 25'(eang) - 25'(prev_a);
  assign div_num = {p[35:0], 16'b0};
  assign drv_l = ggd_pkg::drive_duty(base, turn_term, duty_floor, duty_ceiling);
  assign drv_r = ggd_pkg::drive_duty(base, -turn_term, duty_floor, duty_ceiling);

  ggd_cordic u_cordic (
    .clk(clk), .rst(rst), .start(cordic_start),
    .dx(17'(target_x) - 17'(pos_x)), .dy(17'(target_y) - 17'(pos_y)),
    .done(cordic_done), .mag_x(cx), .ang_z(cz)
  );

  ggd_divider u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(dt_r),
    .done(div_done), .quo(div_quo)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ggd_pkg::ST_IDLE: if (accept && run) state_next = ggd_pkg::ST_CORDIC;
      ggd_pkg::ST_CORDIC: if (cordic_done) state_next = ggd_pkg::ST_MAG;
      ggd_pkg::ST_MAG: state_next = ggd_pkg::ST_CHK;
      ggd_pkg::ST_CHK: state_next = (dist_c < ggd_pkg::STOP_RADIUS) ? ggd_pkg::ST_EMIT
                                                                     : ggd_pkg::ST_WRAP;
      ggd_pkg::ST_WRAP: begin
        if (eang <= ggd_pkg::HALF_TURN && eang >= -ggd_pkg::HALF_TURN) begin
          state_next = ggd_pkg::ST_M1;
        end
      end
      ggd_pkg::ST_M1: state_next = ggd_pkg::ST_M2;
      ggd_pkg::ST_M2: state_next = ggd_pkg::ST_M3;
      ggd_pkg::ST_M3: state_next = ggd_pkg::ST_M4;
      ggd_pkg::ST_M4: state_next = ggd_pkg::ST_M5;
      ggd_pkg::ST_M5: state_next = ggd_pkg::ST_M6;
      ggd_pkg::ST_M6: state_next = ggd_pkg::ST_M7;
      ggd_pkg::ST_M7: state_next = ggd_pkg::ST_M8;
      ggd_pkg::ST_M8: state_next = ggd_pkg::ST_DIV1;
      ggd_pkg::ST_DIV1: if (div_done) state_next = ggd_pkg::ST_DIV1B;
      ggd_pkg::ST_DIV1B: state_next = ggd_pkg::ST_DIV2;
      ggd_pkg::ST_DIV2: if (div_done) state_next = ggd_pkg::ST_BASE;
      ggd_pkg::ST_BASE: state_next = ggd_pkg::ST_TURN;
      ggd_pkg::ST_TURN: state_next = ggd_pkg::ST_DRV;
      ggd_pkg::ST_DRV: state_next = ggd_pkg::ST_EMIT;
      ggd_pkg::ST_EMIT: if (out_free) state_next = ggd_pkg::ST_IDLE;
      default: state_next = ggd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cordic_start = 1'b0;
    div_start = 1'b0;
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      ggd_pkg::ST_IDLE: cordic_start = accept && run;
      ggd_pkg::ST_MAG: begin
        mul_a = ggd_pkg::INV_GAIN;
        mul_b = 33'(cx);
      end
      ggd_pkg::ST_M1: begin
        mul_a = $signed({1'b0, dt_r});
        mul_b = $signed({15'b0, dist_q});
      end
      ggd_pkg::ST_M2: begin
        mul_a = $signed({1'b0, dt_r});
        mul_b = 33'(eang);
      end
      ggd_pkg::ST_M3: begin
        mul_a = 17'(kp_l);
        mul_b = $signed({15'b0, dist_q});
      end
      ggd_pkg::ST_M4: begin
        mul_a = 17'(ki_l);
        mul_b = 33'(dint);
      end
      ggd_pkg::ST_M5: begin
        mul_a = 17'(kd_l);
        mul_b = 33'(diff_d);
      end
      ggd_pkg::ST_M6: begin
        mul_a = 17'(kp_a);
        mul_b = 33'(eang);
        div_start = 1'b1;
      end
      ggd_pkg::ST_M7: begin
        mul_a = 17'(ki_a);
        mul_b = 33'(aint);
      end
      ggd_pkg::ST_M8: begin
        mul_a = 17'(kd_a);
        mul_b = 33'(diff_a);
      end
      ggd_pkg::ST_DIV1B: div_start = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ggd_pkg::ST_IDLE;
      out_valid <= 1'b0;
      kp_l <= 16'sd307;
      ki_l <= 16'sd0;
      kd_l <= 16'sd13;
      kp_a <= 16'sd512;
      ki_a <= 16'sd0;
      kd_a <= 16'sd26;
      duty_floor <= 8'd60;
      duty_ceiling <= 8'd220;
      halted <= 1'b1;
      target_x <= '0;
      target_y <= '0;
      dint <= '0;
      aint <= '0;
      prev_d <= '0;
      prev_a <= '0;
    end else begin
      state <= state_next;
      out_valid <= emit || (out_valid && out_stall);

      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          ggd_pkg::REG_KP_LIN: kp_l <= cfg_data;
          ggd_pkg::REG_KI_LIN: ki_l <= cfg_data;
          ggd_pkg::REG_KD_LIN: kd_l <= cfg_data;
          ggd_pkg::REG_KP_ANG: kp_a <= cfg_data;
          ggd_pkg::REG_KI_ANG: ki_a <= cfg_data;
          ggd_pkg::REG_KD_ANG: kd_a <= cfg_data;
          ggd_pkg::REG_FLOOR: duty_floor <= cfg_data[7:0];
          ggd_pkg::REG_CEIL: duty_ceiling <= cfg_data[7:0];
          default: ;
        endcase
      end

      unique case (state)
        ggd_pkg::ST_IDLE: begin
          if (accept) begin
            hd_r <= heading;
            dt_r <= time_step;
            if (!run) begin
              command <= (action == ggd_pkg::ACT_STOP) ? ggd_pkg::CMD_OFF : ggd_pkg::CMD_HOLD;
              left_duty <= '0;
              left_forward <= 1'b0;
              right_duty <= '0;
              right_forward <= 1'b0;
              goal_reached <= 1'b0;
              if (action == ggd_pkg::ACT_GOAL) begin
                target_x <= pos_x;
                target_y <= pos_y;
                halted <= 1'b0;
              end else if (action == ggd_pkg::ACT_STOP) begin
                halted <= 1'b1;
                dint <= '0;
                aint <= '0;
                prev_d <= '0;
                prev_a <= '0;
              end
            end
          end
        end
        ggd_pkg::ST_MAG: p <= prod;
        ggd_pkg::ST_CHK: begin
          res_l <= '0;
          res_r <= '0;
          if (dist_c < ggd_pkg::STOP_RADIUS) begin
            res_cmd <= ggd_pkg::CMD_OFF;
            res_goal <= 1'b1;
            halted <= 1'b1;
            dint <= '0;
            aint <= '0;
            prev_d <= '0;
            prev_a <= '0;
          end else begin
            dist_q <= dist_c;
            eang <= eang_c;
          end
        end
        ggd_pkg::ST_WRAP: begin
          if (eang > ggd_pkg::HALF_TURN) eang <= eang - ggd_pkg::FULL_TURN;
          else if (eang < -ggd_pkg::HALF_TURN) eang <= eang + ggd_pkg::FULL_TURN;
        end
        ggd_pkg::ST_M1: p <= prod;
        ggd_pkg::ST_M2: begin
          dint <= clamp_int(dint, p, ggd_pkg::LIN_INT_LIMIT);
          p <= prod;
        end
        ggd_pkg::ST_M3: begin
          aint <= clamp_int(aint, p, ggd_pkg::ANG_INT_LIMIT);
          p <= prod;
        end
        ggd_pkg::ST_M4: begin
          acc_l <= ggd_pkg::ACC_W'(p);
          p <= prod;
        end
        ggd_pkg::ST_M5: begin
          acc_l <= acc_l + ggd_pkg::ACC_W'(p >>> 16);
          p <= prod;
        end
        ggd_pkg::ST_M6: p <= prod;
        ggd_pkg::ST_M7: begin
          acc_a <= ggd_pkg::ACC_W'(p);
          p <= prod;
        end
        ggd_pkg::ST_M8: begin
          acc_a <= acc_a + ggd_pkg::ACC_W'(p >>> 16);
          p <= prod;
        end
        ggd_pkg::ST_DIV1: begin
          if (div_done) begin
            acc_l <= acc_l + ggd_pkg::ACC_W'(div_quo);
            prev_d <= 24'(dist_q);
          end
        end
        ggd_pkg::ST_DIV2: begin
          if (div_done) begin
            acc_a <= acc_a + ggd_pkg::ACC_W'(div_quo);
            prev_a <= 24'(eang);
          end
        end
        ggd_pkg::ST_BASE: begin
          base <= clamp_cap((64'(acc_l) <<< 5) + (64'(acc_l) <<< 3), duty_ceiling);
        end
        ggd_pkg::ST_TURN: begin
          turn_term <= clamp_cap((64'(acc_a) <<< 5) + (64'(acc_a) <<< 4), duty_ceiling);
        end
        ggd_pkg::ST_DRV: begin
          res_cmd <= ggd_pkg::CMD_DRIVE;
          res_goal <= 1'b0;
          res_l <= drv_l;
          res_r <= drv_r;
        end
        ggd_pkg::ST_EMIT: begin
          if (out_free) begin
            command <= res_cmd;
            left_duty <= res_l.duty;
            left_forward <= res_l.fwd;
            right_duty <= res_r.duty;
            right_forward <= res_r.fwd;
            goal_reached <= res_goal;
          end
        end
        default: ;
      endcase
    end
  end

endmodule
